FILE: rtl/rhp_pkg.sv
// Shared constants, types and the helper function of the RGB/HSV converter.
package rhp_pkg;

  localparam int PALETTE_COUNT = 5;
  localparam int HUE_BITS      = 16;

  localparam int KW        = $clog2(PALETTE_COUNT + 1);
  localparam int HUE_STEP  = ((1 << HUE_BITS) + 5) / 10;
  localparam int D6W       = 11;   // six times an 8-bit difference
  localparam int DENW      = HUE_BITS + 8;
  localparam int SAT_STEPS = 8;

  localparam logic [1:0] OP_RGB2HSV = 2'd0;
  localparam logic [1:0] OP_HSV2RGB = 2'd1;
  localparam logic [1:0] OP_PALETTE = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  localparam logic [DENW-1:0] HUE_DEN = DENW'(255) << HUE_BITS;
  localparam logic [HUE_BITS:0] HUE_ONE = (HUE_BITS+1)'(1) << HUE_BITS;

  // State carried along the divider chain.
  typedef struct packed {
    logic                valid;
    logic                last;
    logic [1:0]          op;
    logic [KW-1:0]       k;
    logic [HUE_BITS-1:0] hin;
    logic [7:0]          sin;
    logic [7:0]          vin;
    logic [7:0]          mx;
    logic [D6W-1:0]      d6;
    logic [D6W-1:0]      hrem;
    logic [HUE_BITS-1:0] hq;
    logic [7:0]          srem;
    logic [7:0]          sdvd;
    logic [7:0]          sq;
  } rhp_div_t;

  typedef struct packed {
    logic                valid;
    logic                last;
    logic [1:0]          op;
    logic [HUE_BITS-1:0] h;
    logic [7:0]          s;
    logic [7:0]          v;
  } rhp_hsv_t;

  typedef struct packed {
    logic                valid;
    logic                last;
    logic [7:0]          r;
    logic [7:0]          g;
    logic [7:0]          b;
    logic [HUE_BITS-1:0] h;
    logic [7:0]          s;
    logic [7:0]          v;
  } rhp_res_t;

  // Floor of y/255, exact for every y up to 255*255.
  function automatic logic [7:0] div255(logic [15:0] y);
    logic [16:0] acc;
    acc = {1'b0, y} + {9'b0, y[15:8]} + 17'd1;
    return acc[15:8];
  endfunction

endpackage

FILE: rtl/rgb_hsv_converter_with_palette.sv
// Top level of the RGB/HSV converter with hue-rotation palette output.
//
// Usage: drive the item fields and raise start; the item transfers at a
// rising edge where start is high and busy is low. Operation 0 turns the
// RGB operand into HSV, operation 1 turns the HSV operand into RGB, and
// operation 2 yields five RGB colors whose hues step by about a tenth of a
// turn. Operation 3 transfers but yields nothing.
// Results come out one per cycle with out_valid high for that single cycle;
// the receiver cannot hold them off. out_last marks the final result of an
// item.
// The entry register loads at the transfer edge; each result then passes
// through 16 chain cells (one per hue quotient bit) and four stages of HSV
// to RGB arithmetic, all registered, before it reaches the outputs. Modes 0
// and 1 take one item per cycle. A palette item stays in the entry register
// while it replays itself once per color with the palette index counting
// up, so busy stays high after it transfers until its final color is in
// the entry register. That replay register alone sets the palette rate.
// A synchronous reset drops every item in flight and clears busy.
module rgb_hsv_converter_with_palette
  import rhp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_operation,
  input  logic [7:0]          in_red_in,
  input  logic [7:0]          in_green_in,
  input  logic [7:0]          in_blue_in,
  input  logic [HUE_BITS-1:0] in_hue_in,
  input  logic [7:0]          in_sat_in,
  input  logic [7:0]          in_val_in,
  output logic                out_valid,
  output logic [7:0]          out_red_out,
  output logic [7:0]          out_green_out,
  output logic [7:0]          out_blue_out,
  output logic [HUE_BITS-1:0] out_hue_out,
  output logic [7:0]          out_sat_out,
  output logic [7:0]          out_val_out,
  output logic                out_last
);

  // Entry register. A palette item stays here, replaying once per color.
  logic                valid_r, last_r;
  logic [1:0]          op_r;
  logic [KW-1:0]       k_r;
  logic [7:0]          red_r, grn_r, blu_r, sat_r, val_r;
  logic [HUE_BITS-1:0] hue_r;
  logic                accept;

  assign busy   = valid_r && (op_r == OP_PALETTE) && (k_r != KW'(PALETTE_COUNT - 1));
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      k_r     <= '0;
      last_r  <= 1'b0;
    end else if (busy) begin
      k_r    <= k_r + KW'(1);
      last_r <= (k_r + KW'(1)) == KW'(PALETTE_COUNT - 1);
    end else if (accept) begin
      valid_r <= in_operation != OP_NONE;
      k_r     <= '0;
      last_r  <= (in_operation != OP_PALETTE) || (PALETTE_COUNT == 1);
    end else begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_operation;
      red_r <= in_red_in;
      grn_r <= in_green_in;
      blu_r <= in_blue_in;
      hue_r <= in_hue_in;
      sat_r <= in_sat_in;
      val_r <= in_val_in;
    end
  end

  // Max/min, sector numerator and divisors for the chain.
  logic [7:0]     mx, mn, d;
  logic [D6W-1:0] d6, num;
  logic [15:0]    sdvd;
  rhp_div_t       chain [0:HUE_BITS];

  always_comb begin
    mx = red_r;
    if (grn_r > mx) mx = grn_r;
    if (blu_r > mx) mx = blu_r;
    mn = red_r;
    if (grn_r < mn) mn = grn_r;
    if (blu_r < mn) mn = blu_r;
    d    = mx - mn;
    d6   = D6W'(d) * D6W'(6);
    sdvd = 16'(d) * 16'(255);
    // Red wins ties, then green.
    if (mx == red_r) begin
      if (grn_r >= blu_r) num = D6W'(grn_r - blu_r);
      else                num = d6 - D6W'(blu_r - grn_r);
    end else if (mx == grn_r) begin
      num = D6W'({d, 1'b0}) + D6W'(blu_r) - D6W'(red_r);
    end else begin
      num = D6W'({d, 2'b0}) + D6W'(red_r) - D6W'(grn_r);
    end

    chain[0].valid = valid_r;
    chain[0].last  = last_r;
    chain[0].op    = op_r;
    chain[0].k     = k_r;
    chain[0].hin   = hue_r;
    chain[0].sin   = sat_r;
    chain[0].vin   = val_r;
    chain[0].mx    = mx;
    chain[0].d6    = d6;
    chain[0].hrem  = num;
    chain[0].hq    = '0;
    chain[0].srem  = sdvd[15:8];
    chain[0].sdvd  = sdvd[7:0];
    chain[0].sq    = '0;
  end

  for (genvar i = 0; i < HUE_BITS; i++) begin : g_cell
    rhp_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .sat_en (i < SAT_STEPS),
      .d_i    (chain[i]),
      .d_o    (chain[i+1])
    );
  end

  // Pick the HSV operand of the back end and rotate palette hues.
  rhp_div_t            tail;
  rhp_hsv_t            hsv;
  logic [HUE_BITS-1:0] hue_base;
  rhp_res_t            res;

  assign tail = chain[HUE_BITS];

  always_comb begin
    hue_base  = (tail.d6 == '0) ? '0 : tail.hq;
    hsv.valid = tail.valid;
    hsv.last  = tail.last;
    hsv.op    = tail.op;
    if (tail.op == OP_HSV2RGB) begin
      hsv.h = tail.hin;
      hsv.s = tail.sin;
      hsv.v = tail.vin;
    end else begin
      hsv.h = hue_base + HUE_BITS'(tail.k * HUE_STEP);
      hsv.s = (tail.mx == 8'd0) ? 8'd0 : tail.sq;
      hsv.v = tail.mx;
    end
  end

  rhp_hsv2rgb u_hsv2rgb (
    .clk   (clk),
    .rst_n (rst_n),
    .hsv_i (hsv),
    .res_o (res)
  );

  assign out_valid     = res.valid;
  assign out_last      = res.last;
  assign out_red_out   = res.r;
  assign out_green_out = res.g;
  assign out_blue_out  = res.b;
  assign out_hue_out   = res.h;
  assign out_sat_out   = res.s;
  assign out_val_out   = res.v;

  // Palette colors leave back to back, so a non-final result is followed.
  a_palette_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("palette burst broken");

  // Non-final results only come from palette items, which carry no HSV.
  a_palette_no_hsv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_hue_out == '0 && out_val_out == '0)
    else $error("palette result carries hsv fields");

  // The replay window opens only right after a palette transfer.
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(accept) && $past(in_operation) == OP_PALETTE)
    else $error("busy without a palette transfer");

endmodule

FILE: rtl/rhp_cell.sv
// One cell of the divider chain: one hue quotient bit and, when sat_en is set, one saturation bit.
module rhp_cell
  import rhp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     sat_en,
  input  rhp_div_t d_i,
  output rhp_div_t d_o
);

  rhp_div_t d_r;
  rhp_div_t d_nxt;

  logic [D6W:0] htry;
  logic [8:0]   stry;

  always_comb begin
    d_nxt = d_i;
    htry  = {d_i.hrem, 1'b0};
    if (htry >= {1'b0, d_i.d6}) begin
      d_nxt.hrem = D6W'(htry - {1'b0, d_i.d6});
      d_nxt.hq   = {d_i.hq[HUE_BITS-2:0], 1'b1};
    end else begin
      d_nxt.hrem = htry[D6W-1:0];
      d_nxt.hq   = {d_i.hq[HUE_BITS-2:0], 1'b0};
    end
    stry = {d_i.srem, d_i.sdvd[7]};
    if (sat_en) begin
      d_nxt.sdvd = {d_i.sdvd[6:0], 1'b0};
      if (stry >= {1'b0, d_i.mx}) begin
        d_nxt.srem = 8'(stry - {1'b0, d_i.mx});
        d_nxt.sq   = {d_i.sq[6:0], 1'b1};
      end else begin
        d_nxt.srem = stry[7:0];
        d_nxt.sq   = {d_i.sq[6:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r <= '0;
    end else begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

FILE: rtl/rhp_hsv2rgb.sv
// Four-stage HSV to RGB pipeline with the six-sector p/q/t rule.
module rhp_hsv2rgb
  import rhp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  rhp_hsv_t hsv_i,
  output rhp_res_t res_o
);

  rhp_hsv_t a_r;

  logic                b_valid_r, b_last_r;
  logic [1:0]          b_op_r;
  logic [HUE_BITS-1:0] b_h_r;
  logic [7:0]          b_s_r, b_v_r;
  logic [2:0]          b_sec_r;
  logic [DENW-1:0]     b_dq_r, b_dt_r;
  logic [15:0]         b_pn_r;

  logic                c_valid_r, c_last_r;
  logic [1:0]          c_op_r;
  logic [HUE_BITS-1:0] c_h_r;
  logic [7:0]          c_s_r, c_v_r;
  logic [2:0]          c_sec_r;
  logic [15:0]         c_yq_r, c_yt_r;
  logic [7:0]          c_p_r;

  rhp_res_t res_r;
  rhp_res_t res_nxt;

  logic [HUE_BITS+2:0] six;
  logic [HUE_BITS-1:0] f;
  logic [DENW-1:0]     fs;
  logic [HUE_BITS+8:0] fts;
  logic [7:0]          q, t, vv, pp;

  always_comb begin
    six = (HUE_BITS+3)'(a_r.h) * (HUE_BITS+3)'(6);
    f   = six[HUE_BITS-1:0];
    fs  = DENW'(f) * DENW'(a_r.s);
    fts = (HUE_ONE - {1'b0, f}) * (HUE_BITS+9)'(a_r.s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r       <= '0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      a_r       <= hsv_i;
      b_valid_r <= a_r.valid;
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    b_last_r <= a_r.last;
    b_op_r   <= a_r.op;
    b_h_r    <= a_r.h;
    b_s_r    <= a_r.s;
    b_v_r    <= a_r.v;
    b_sec_r  <= six[HUE_BITS+2:HUE_BITS];
    b_dq_r   <= HUE_DEN - fs;
    b_dt_r   <= HUE_DEN - fts[DENW-1:0];
    b_pn_r   <= 16'(a_r.v) * 16'(8'd255 - a_r.s);

    c_last_r <= b_last_r;
    c_op_r   <= b_op_r;
    c_h_r    <= b_h_r;
    c_s_r    <= b_s_r;
    c_v_r    <= b_v_r;
    c_sec_r  <= b_sec_r;
    c_p_r    <= div255(b_pn_r);
  end

  // The value scales both q and t numerators in the same stage; the final
  // divide by 255 follows in the output stage.
  always_ff @(posedge clk) begin
    c_yq_r <= 16'(({8'd0, b_dq_r} * {{DENW{1'b0}}, b_v_r}) >> HUE_BITS);
    c_yt_r <= 16'(({8'd0, b_dt_r} * {{DENW{1'b0}}, b_v_r}) >> HUE_BITS);
  end

  always_comb begin
    q  = div255(c_yq_r);
    t  = div255(c_yt_r);
    vv = c_v_r;
    pp = c_p_r;
    res_nxt       = '0;
    res_nxt.valid = c_valid_r;
    res_nxt.last  = c_last_r;
    if (c_op_r == OP_RGB2HSV) begin
      res_nxt.h = c_h_r;
      res_nxt.s = c_s_r;
      res_nxt.v = c_v_r;
    end else begin
      case (c_sec_r)
        3'd0:    begin res_nxt.r = vv; res_nxt.g = t;  res_nxt.b = pp; end
        3'd1:    begin res_nxt.r = q;  res_nxt.g = vv; res_nxt.b = pp; end
        3'd2:    begin res_nxt.r = pp; res_nxt.g = vv; res_nxt.b = t;  end
        3'd3:    begin res_nxt.r = pp; res_nxt.g = q;  res_nxt.b = vv; end
        3'd4:    begin res_nxt.r = t;  res_nxt.g = pp; res_nxt.b = vv; end
        default: begin res_nxt.r = vv; res_nxt.g = pp; res_nxt.b = q;  end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      res_r <= res_nxt;
    end
  end

  assign res_o = res_r;

endmodule
